// ===== src/slot_buffer_pool_macros.svh =====
// Assertion macros shared by the slot buffer pool RTL.
// Depends on nothing; expects clk and rst_n in the asserting module.
`ifndef SLOT_BUFFER_POOL_MACROS_SVH
`define SLOT_BUFFER_POOL_MACROS_SVH

`ifndef SYNTHESIS
`define SBP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot buffer pool check failed");
`define SBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot buffer pool sequence check failed");
`else
`define SBP_ASSERT_IMPLY(label, ante, cons)
`define SBP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/sbp_pkg.sv =====
// Shared types, widths and codes for the slot buffer pool.
// Depends on nothing.
package sbp_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int LEN_W    = 32;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;

    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILLED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic quick;
        logic eval;
    } cmd_t;

    typedef struct packed {
        logic zero_alloc;
        logic hit;
        logic last;
    } stat_t;

endpackage

// ===== src/slot_buffer_pool.sv =====
// Slot buffer pool top level: sequencer plus slot table datapath.
// Depends on sbp_pkg, sbp_ctrl, sbp_datapath (and sbp_ram below it).
//
//  channel   handshake        word
//  request   start / busy     kind, request_bytes, fresh_address, release_address
//  result    done (strobe)    status, granted_address, slot_index
//
// A zero-byte allocate gives its result the cycle after acceptance, busy stays low.
// Any other request scans one slot per cycle through the registered table RAM read:
// k slots examined (1..SLOTS) keep busy high while the scan runs; the result is shown
// as busy falls, and a new word can be taken in that same cycle.
// Reset clears the valid and in-use flags at once; no clearing pass is needed.
// Results are shown for one cycle and cannot be stalled.
module slot_buffer_pool #(
    parameter int SLOTS = sbp_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [sbp_pkg::LEN_W-1:0]      request_bytes,
    input  logic [sbp_pkg::ADDR_W-1:0]     fresh_address,
    input  logic [sbp_pkg::ADDR_W-1:0]     release_address,
    output logic                           done,
    output logic [sbp_pkg::STATUS_W-1:0]   status,
    output logic [sbp_pkg::ADDR_W-1:0]     granted_address,
    output logic [sbp_pkg::INDEX_W-1:0]    slot_index
);

    sbp_pkg::cmd_t  cmd;
    sbp_pkg::stat_t stat;

    sbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sbp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .request_bytes   (request_bytes),
        .fresh_address   (fresh_address),
        .release_address (release_address),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .slot_index      (slot_index)
    );

endmodule

// ===== src/sbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sbp_ctrl.sv =====
// Request sequencer for the slot buffer pool: idle / scan state machine.
// Depends on sbp_pkg and slot_buffer_pool_macros.svh.
`include "slot_buffer_pool_macros.svh"

module sbp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sbp_pkg::stat_t stat,
    output sbp_pkg::cmd_t  cmd,
    output logic           busy
);

    sbp_pkg::state_t state_reg;
    sbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbp_pkg::S_IDLE:
            begin
                if (start && !stat.zero_alloc)
                begin
                    state_next = sbp_pkg::S_SCAN;
                end
            end
            sbp_pkg::S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = sbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sbp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        unique case (state_reg)
            sbp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.quick = stat.zero_alloc;
                    cmd.load  = !stat.zero_alloc;
                end
            end
            sbp_pkg::S_SCAN:
            begin
                busy     = 1'b1;
                cmd.eval = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    `SBP_ASSERT_NEXT(a_scan_exit, state_reg == sbp_pkg::S_SCAN && (stat.hit || stat.last), state_reg == sbp_pkg::S_IDLE)
    `SBP_ASSERT_IMPLY(a_no_load_in_scan, state_reg == sbp_pkg::S_SCAN, !cmd.load && !cmd.quick)

endmodule

// ===== src/sbp_datapath.sv =====
// Slot table, request latch, slot compare and result registers.
// Depends on sbp_pkg, sbp_ram and slot_buffer_pool_macros.svh.
`include "slot_buffer_pool_macros.svh"

module sbp_datapath #(
    parameter int SLOTS = sbp_pkg::SLOTS_DEFAULT,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbp_pkg::cmd_t                  cmd,
    output sbp_pkg::stat_t                 stat,
    input  logic                           kind,
    input  logic [sbp_pkg::LEN_W-1:0]      request_bytes,
    input  logic [sbp_pkg::ADDR_W-1:0]     fresh_address,
    input  logic [sbp_pkg::ADDR_W-1:0]     release_address,
    output logic                           done,
    output logic [sbp_pkg::STATUS_W-1:0]   status,
    output logic [sbp_pkg::ADDR_W-1:0]     granted_address,
    output logic [sbp_pkg::INDEX_W-1:0]    slot_index
);

    logic                          kind_reg;
    logic [sbp_pkg::LEN_W-1:0]     bytes_reg;
    logic [sbp_pkg::ADDR_W-1:0]    fresh_reg;
    logic [sbp_pkg::ADDR_W-1:0]    rel_reg;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;
    logic [IW-1:0]                 idx_inc;
    logic [IW-1:0]                 rd_addr;

    logic [SLOTS-1:0]              valid_reg;
    logic [SLOTS-1:0]              valid_next;
    logic [SLOTS-1:0]              in_use_reg;
    logic [SLOTS-1:0]              in_use_next;

    logic [sbp_pkg::LEN_W-1:0]     len_rd;
    logic [sbp_pkg::ADDR_W-1:0]    addr_rd;

    logic                          alloc_reuse;
    logic                          alloc_fill;
    logic                          rel_hit;
    logic                          hit;
    logic                          last;
    logic                          ram_we;
    logic [31:0]                   idx_ext;

    logic                          done_reg;
    logic                          done_next;
    logic [sbp_pkg::STATUS_W-1:0]  status_reg;
    logic [sbp_pkg::STATUS_W-1:0]  status_next;
    logic [sbp_pkg::ADDR_W-1:0]    granted_reg;
    logic [sbp_pkg::ADDR_W-1:0]    granted_next;
    logic [sbp_pkg::INDEX_W-1:0]   index_reg;
    logic [sbp_pkg::INDEX_W-1:0]   index_next;

    // read address runs one slot ahead of the compare index
    assign idx_inc = idx_reg + IW'(1);
    assign rd_addr = cmd.load ? '0 : idx_inc;
    assign idx_next = cmd.load ? '0 : ((cmd.eval && !hit) ? idx_inc : idx_reg);
    assign last = (idx_reg == IW'(SLOTS - 1));
    assign idx_ext = 32'(idx_reg);

    assign alloc_fill  = !valid_reg[idx_reg];
    assign alloc_reuse = valid_reg[idx_reg] && (len_rd == bytes_reg) && !in_use_reg[idx_reg];
    assign rel_hit     = in_use_reg[idx_reg] && (addr_rd == rel_reg);
    assign hit = (kind_reg == sbp_pkg::KIND_RELEASE) ? rel_hit : (alloc_reuse || alloc_fill);
    assign ram_we = cmd.eval && (kind_reg == sbp_pkg::KIND_ALLOC) && alloc_fill;

    assign stat.zero_alloc = (kind == sbp_pkg::KIND_ALLOC) && (request_bytes == '0);
    assign stat.hit  = hit;
    assign stat.last = last;

    sbp_ram #(
        .WIDTH (sbp_pkg::LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (bytes_reg),
        .raddr (rd_addr),
        .rdata (len_rd)
    );

    sbp_ram #(
        .WIDTH (sbp_pkg::ADDR_W),
        .DEPTH (SLOTS)
    ) u_addr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (fresh_reg),
        .raddr (rd_addr),
        .rdata (addr_rd)
    );

    always_comb
    begin
        valid_next  = valid_reg;
        in_use_next = in_use_reg;
        if (cmd.eval && hit)
        begin
            if (kind_reg == sbp_pkg::KIND_RELEASE)
            begin
                in_use_next[idx_reg] = 1'b0;
            end
            else
            begin
                valid_next[idx_reg]  = 1'b1;
                in_use_next[idx_reg] = 1'b1;
            end
        end
    end

    always_comb
    begin
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        index_next   = index_reg;
        if (cmd.quick)
        begin
            done_next    = 1'b1;
            status_next  = sbp_pkg::ST_NOSLOT;
            granted_next = '0;
            index_next   = '0;
        end
        else if (cmd.eval && hit)
        begin
            done_next  = 1'b1;
            index_next = idx_ext[sbp_pkg::INDEX_W-1:0];
            if (kind_reg == sbp_pkg::KIND_RELEASE)
            begin
                status_next  = sbp_pkg::ST_RELEASED;
                granted_next = '0;
            end
            else if (alloc_reuse)
            begin
                status_next  = sbp_pkg::ST_REUSED;
                granted_next = addr_rd;
            end
            else
            begin
                status_next  = sbp_pkg::ST_FILLED;
                granted_next = fresh_reg;
            end
        end
        else if (cmd.eval && last)
        begin
            done_next    = 1'b1;
            status_next  = (kind_reg == sbp_pkg::KIND_RELEASE) ?
                           sbp_pkg::ST_NOTFOUND : sbp_pkg::ST_NOSLOT;
            granted_next = '0;
            index_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            in_use_reg <= '0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            in_use_reg <= in_use_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            bytes_reg <= request_bytes;
            fresh_reg <= fresh_address;
            rel_reg   <= release_address;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
        index_reg   <= index_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;
    assign slot_index      = index_reg;

    `SBP_ASSERT_IMPLY(a_in_use_filled, 1'b1, (in_use_reg & ~valid_reg) == '0)
    `SBP_ASSERT_IMPLY(a_grant_marks_in_use, done_reg && (status_reg == sbp_pkg::ST_REUSED || status_reg == sbp_pkg::ST_FILLED), in_use_reg[idx_reg] && valid_reg[idx_reg])
    `SBP_ASSERT_IMPLY(a_release_clears, done_reg && status_reg == sbp_pkg::ST_RELEASED, !in_use_reg[idx_reg])
    `SBP_ASSERT_IMPLY(a_fail_zero, done_reg && (status_reg == sbp_pkg::ST_NOSLOT || status_reg == sbp_pkg::ST_NOTFOUND), granted_reg == '0 && index_reg == '0)

endmodule
